@@ src/mbdu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdu_pkg
// Types and constants shared by the box depth unprojection pipeline.
// ----------------------------------------------------------------------------
package mbdu_pkg;

    localparam int REG_W   = 16;
    localparam int REG_NUM = 8;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_FOCAL_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_FOCAL_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_COL = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTER_ROW = 3'd3;
    localparam logic [IDX_W-1:0] REG_OBST_H     = 3'd4;
    localparam logic [IDX_W-1:0] REG_MOUNT_H    = 3'd5;
    localparam logic [IDX_W-1:0] REG_FLOOR      = 3'd6;
    localparam logic [IDX_W-1:0] REG_CEILING    = 3'd7;

    localparam logic [REG_W-1:0] RST_FOCAL_X    = 16'd8000;
    localparam logic [REG_W-1:0] RST_FOCAL_Y    = 16'd8000;
    localparam logic [REG_W-1:0] RST_CENTER_COL = 16'd5120;
    localparam logic [REG_W-1:0] RST_CENTER_ROW = 16'd3840;
    localparam logic [REG_W-1:0] RST_OBST_H     = 16'd512;
    localparam logic [REG_W-1:0] RST_MOUNT_H    = 16'd256;
    localparam logic [REG_W-1:0] RST_FLOOR      = 16'd128;
    localparam logic [REG_W-1:0] RST_CEILING    = 16'd12800;

    localparam logic [REG_W-1:0] FOCAL_MIN = 16'd16;

    localparam logic [1:0] SRC_SIZE     = 2'd0;
    localparam logic [1:0] SRC_GROUND   = 2'd1;
    localparam logic [1:0] SRC_FALLBACK = 2'd2;

    // depth divider: 33-bit numerator, 16-bit divisor
    localparam int DEPTH_NW = 33;
    // position / velocity dividers
    localparam int POS_NW   = 33;
    localparam int DEN_W    = 16;

    typedef struct packed {
        logic [15:0]        track_tag;
        logic [7:0]         class_tag;
        logic [15:0]        score;
        logic [15:0]        box_col;
        logic [15:0]        box_row;
        logic [15:0]        box_height;
        logic signed [15:0] speed_col;
        logic signed [15:0] speed_row;
    } t_req;

    typedef struct packed {
        logic [15:0]        track_out;
        logic [7:0]         class_out;
        logic [15:0]        score_out;
        logic [15:0]        pos_forward;
        logic signed [23:0] pos_right;
        logic signed [23:0] pos_down;
        logic signed [23:0] vel_right;
        logic signed [23:0] vel_down;
        logic [1:0]         depth_source;
    } t_res;

    // carried alongside the depth division
    typedef struct packed {
        t_req               req;
        logic signed [17:0] du;
        logic signed [17:0] dv;
        logic [1:0]         src;
    } t_mid;

    // carried alongside the position / velocity divisions
    typedef struct packed {
        logic [15:0] track;
        logic [7:0]  cls;
        logic [15:0] score;
        logic [15:0] depth;
        logic [1:0]  src;
    } t_tail;

endpackage

@@ src/mbdu_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdu_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mbdu_div #(
    parameter int NW = 33,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    localparam int AW = DW + NW;

    logic [AW-1:0] r_acc  [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];
    logic          r_vld  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [AW-1:0] w_prev;
        logic [DW-1:0] w_den;
        logic [SW-1:0] w_side;
        logic          w_vld;
        logic [DW:0]   w_top;
        logic [DW:0]   w_sub;
        logic          w_q;
        logic [AW-1:0] n_acc;

        if (k == 0) begin : g_first
            assign w_prev = {{DW{1'b0}}, i_num};
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_vld  = i_vld;
        end else begin : g_next
            assign w_prev = r_acc[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
            assign w_vld  = r_vld[k-1];
        end

        always_comb begin
            w_top = w_prev[AW-1:NW-1];
            w_q   = (w_top >= {1'b0, w_den});
            w_sub = w_q ? (w_top - {1'b0, w_den}) : w_top;
            n_acc = {w_sub[DW-1:0], w_prev[NW-2:0], w_q};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_acc[k]  <= n_acc;
            r_den[k]  <= w_den;
            r_side[k] <= w_side;
        end
    end

    assign o_vld  = r_vld[NW-1];
    assign o_quo  = r_acc[NW-1][NW-1:0];
    assign o_side = r_side[NW-1];

endmodule

@@ src/monocular_box_depth_unproject_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monocular_box_depth_unproject_top
// Pinhole unprojection of tracked boxes with apparent-size / ground-plane depth.
// ----------------------------------------------------------------------------
// Pipeline: capture, rule select, 33-stage depth divider, clamp, products,
// 33-stage position/velocity dividers, output register.
// Throughput: one request per cycle; busy is never raised, since every stage
// advances every cycle. Results cannot be stalled by the receiver.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults.
module monocular_box_depth_unproject_top
    import mbdu_pkg::*;
#(
    parameter int BOX_HEIGHT_THRESHOLD = 160,
    parameter int RAY_DROP_LIMIT       = 3277,
    parameter int FALLBACK_DEPTH       = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_res_vld,
    output t_res             o_res,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data
);

    localparam logic [15:0] BH_THR   = 16'(BOX_HEIGHT_THRESHOLD);
    localparam logic [15:0] RAY_THR  = 16'(RAY_DROP_LIMIT);
    localparam logic [15:0] FB_DEPTH = 16'(FALLBACK_DEPTH);

    // ---------------- configuration registers ----------------
    logic [REG_W-1:0] r_focal_x, r_focal_y, r_center_col, r_center_row;
    logic [REG_W-1:0] r_obst_h, r_mount_h, r_floor, r_ceiling;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x    <= RST_FOCAL_X;
            r_focal_y    <= RST_FOCAL_Y;
            r_center_col <= RST_CENTER_COL;
            r_center_row <= RST_CENTER_ROW;
            r_obst_h     <= RST_OBST_H;
            r_mount_h    <= RST_MOUNT_H;
            r_floor      <= RST_FLOOR;
            r_ceiling    <= RST_CEILING;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FOCAL_X:    r_focal_x    <= i_cfg_data;
                REG_FOCAL_Y:    r_focal_y    <= i_cfg_data;
                REG_CENTER_COL: r_center_col <= i_cfg_data;
                REG_CENTER_ROW: r_center_row <= i_cfg_data;
                REG_OBST_H:     r_obst_h     <= i_cfg_data;
                REG_MOUNT_H:    r_mount_h    <= i_cfg_data;
                REG_FLOOR:      r_floor      <= i_cfg_data;
                REG_CEILING:    r_ceiling    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [15:0] w_fxf, w_fyf;
    assign w_fxf = (r_focal_x < FOCAL_MIN) ? FOCAL_MIN : r_focal_x;
    assign w_fyf = (r_focal_y < FOCAL_MIN) ? FOCAL_MIN : r_focal_y;

    assign busy = 1'b0;

    // ---------------- stage 0: capture request ----------------
    logic r_s0_vld;
    t_req r_s0_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_req <= i_req;
    end

    // ---------------- stage 1: offsets, rule select, numerator product -------
    logic signed [17:0] w_du, w_dv;
    logic signed [33:0] w_dv_sh, w_ray_lim;
    logic               w_tall, w_below;
    logic [31:0]        w_prod;
    logic [15:0]        w_den;
    logic [1:0]         w_src;

    always_comb begin
        w_du      = $signed({2'b00, r_s0_req.box_col}) - $signed({2'b00, r_center_col});
        w_dv      = $signed({2'b00, r_s0_req.box_row}) - $signed({2'b00, r_center_row});
        w_dv_sh   = {w_dv, 16'd0};
        w_ray_lim = $signed({2'b00, 32'(RAY_THR) * 32'(w_fyf)});
        w_tall    = r_s0_req.box_height > BH_THR;
        w_below   = w_dv_sh > w_ray_lim;
        if (w_tall) begin
            w_src  = SRC_SIZE;
            w_prod = 32'(r_obst_h) * 32'(r_focal_y);
            w_den  = r_s0_req.box_height;
        end else if (w_below) begin
            w_src  = SRC_GROUND;
            w_prod = 32'(r_mount_h) * 32'(w_fyf);
            w_den  = w_dv[15:0];   // positive and below 2^16 here
        end else begin
            w_src  = SRC_FALLBACK;
            w_prod = 32'd0;
            w_den  = 16'd1;
        end
    end

    logic        r_s1_vld;
    t_mid        r_s1_mid;
    logic [31:0] r_s1_prod;
    logic [15:0] r_s1_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_mid  <= '{req: r_s0_req, du: w_du, dv: w_dv, src: w_src};
        r_s1_prod <= w_prod;
        r_s1_den  <= w_den;
    end

    // ---------------- depth division ----------------
    logic [DEPTH_NW-1:0] w_dnum;
    assign w_dnum = {1'b0, r_s1_prod} + {18'd0, r_s1_den[15:1]};

    logic                d1_vld;
    logic [DEPTH_NW-1:0] d1_quo;
    logic [$bits(t_mid)-1:0] d1_side;
    t_mid                d1_mid;

    mbdu_div #(.NW(DEPTH_NW), .DW(DEN_W), .SW($bits(t_mid))) u_div_depth (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_s1_vld),
        .i_num  (w_dnum),
        .i_den  (r_s1_den),
        .i_side (r_s1_mid),
        .o_vld  (d1_vld),
        .o_quo  (d1_quo),
        .o_side (d1_side)
    );
    assign d1_mid = t_mid'(d1_side);

    // ---------------- stage 3: clamp ----------------
    logic [15:0] w_depth;
    always_comb begin
        if (d1_mid.src == SRC_FALLBACK) begin
            w_depth = FB_DEPTH;
        end else if (d1_quo < {17'd0, r_floor}) begin
            w_depth = r_floor;
        end else if (d1_quo > {17'd0, r_ceiling}) begin
            w_depth = r_ceiling;
        end else begin
            w_depth = d1_quo[15:0];
        end
    end

    logic        r_s3_vld;
    t_mid        r_s3_mid;
    logic [15:0] r_s3_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_mid   <= d1_mid;
        r_s3_depth <= w_depth;
    end

    // ---------------- stage 4: depth times offset / speed ----------------
    logic signed [34:0] w_p [4];
    logic signed [16:0] w_dep_s;
    logic [3:0]         w_neg;
    logic [POS_NW-1:0]  w_mag [4];

    always_comb begin
        w_dep_s = $signed({1'b0, r_s3_depth});
        w_p[0]  = 35'(r_s3_mid.du) * 35'(w_dep_s);
        w_p[1]  = 35'(r_s3_mid.dv) * 35'(w_dep_s);
        w_p[2]  = 35'(r_s3_mid.req.speed_col) * 35'(w_dep_s);
        w_p[3]  = 35'(r_s3_mid.req.speed_row) * 35'(w_dep_s);
        for (int j = 0; j < 4; j++) begin
            w_neg[j] = w_p[j][34];
            w_mag[j] = w_neg[j] ? POS_NW'(-w_p[j]) : POS_NW'(w_p[j]);
        end
    end

    logic              r_s4_vld;
    logic [POS_NW-1:0] r_s4_mag [4];
    logic [3:0]        r_s4_neg;
    t_tail             r_s4_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_mag  <= w_mag;
        r_s4_neg  <= w_neg;
        r_s4_tail <= '{track: r_s3_mid.req.track_tag, cls: r_s3_mid.req.class_tag,
                       score: r_s3_mid.req.score, depth: r_s3_depth,
                       src: r_s3_mid.src};
    end

    // ---------------- position / velocity division ----------------
    logic [15:0]       w_pden [4];
    logic [POS_NW-1:0] w_pnum [4];
    logic [3:0]        p_vld;
    logic [POS_NW-1:0] p_quo [4];
    logic [$bits(t_tail):0] p_side0;
    logic [2:0]        p_side_neg;

    always_comb begin
        w_pden[0] = w_fxf;
        w_pden[1] = w_fyf;
        w_pden[2] = w_fxf;
        w_pden[3] = w_fyf;
        for (int j = 0; j < 4; j++) begin
            w_pnum[j] = r_s4_mag[j] + {18'd0, w_pden[j][15:1]};
        end
    end

    mbdu_div #(.NW(POS_NW), .DW(DEN_W), .SW($bits(t_tail) + 1)) u_div_pos0 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_s4_vld),
        .i_num  (w_pnum[0]),
        .i_den  (w_pden[0]),
        .i_side ({r_s4_neg[0], r_s4_tail}),
        .o_vld  (p_vld[0]),
        .o_quo  (p_quo[0]),
        .o_side (p_side0)
    );

    for (genvar g = 1; g < 4; g++) begin : g_pdiv
        mbdu_div #(.NW(POS_NW), .DW(DEN_W), .SW(1)) u_div_pos (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (r_s4_vld),
            .i_num  (w_pnum[g]),
            .i_den  (w_pden[g]),
            .i_side (r_s4_neg[g]),
            .o_vld  (p_vld[g]),
            .o_quo  (p_quo[g]),
            .o_side (p_side_neg[g-1])
        );
    end

    // ---------------- stage 6: saturate and drive result ----------------
    function automatic logic [23:0] sat24(input logic [POS_NW-1:0] q, input logic neg);
        logic [POS_NW-1:0] lim;
        logic [POS_NW-1:0] qc;
        lim = neg ? POS_NW'(24'h800000) : POS_NW'(24'h7FFFFF);
        qc  = (q > lim) ? lim : q;
        return neg ? 24'(-qc) : qc[23:0];
    endfunction

    t_tail      w_tail;
    logic [3:0] w_oneg;
    assign w_tail = t_tail'(p_side0[$bits(t_tail)-1:0]);
    assign w_oneg = {p_side_neg, p_side0[$bits(t_tail)]};

    logic r_out_vld;
    t_res r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= p_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.track_out    <= w_tail.track;
        r_out.class_out    <= w_tail.cls;
        r_out.score_out    <= w_tail.score;
        r_out.pos_forward  <= w_tail.depth;
        r_out.pos_right    <= sat24(p_quo[0], w_oneg[0]);
        r_out.pos_down     <= sat24(p_quo[1], w_oneg[1]);
        r_out.vel_right    <= sat24(p_quo[2], w_oneg[2]);
        r_out.vel_down     <= sat24(p_quo[3], w_oneg[3]);
        r_out.depth_source <= w_tail.src;
    end

    assign o_res_vld = r_out_vld;
    assign o_res     = r_out;

    // ---------------- assertions ----------------
    a_src_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> (o_res.depth_source != 2'd3))
        else $error("invalid depth source code");

    a_fallback_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_res.depth_source == SRC_FALLBACK) |-> (o_res.pos_forward == FB_DEPTH))
        else $error("fallback depth mismatch");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_res.depth_source != SRC_FALLBACK && r_floor <= r_ceiling)
        |-> (o_res.pos_forward >= r_floor && o_res.pos_forward <= r_ceiling))
        else $error("depth outside clamp window");

    a_div_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_vld[0] |-> (p_vld == 4'hF))
        else $error("divider lanes out of step");

endmodule

@@ sim/mbdu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdu_checker
// Scoreboard for the box depth unprojection block. It mirrors the camera
// registers from the write port, predicts each result when a request is
// accepted, and compares the strobed results in order, field by field.
// ----------------------------------------------------------------------------
module mbdu_checker
    import mbdu_pkg::*;
#(
    parameter int BOX_HEIGHT_THRESHOLD = 160,
    parameter int RAY_DROP_LIMIT       = 3277,
    parameter int FALLBACK_DEPTH       = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  t_req             i_req,
    input  logic             i_res_vld,
    input  t_res             i_res,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data,
    output int               o_fail_cnt,
    output int               o_pending,
    output int               o_src_cnt [3]
);

    logic [REG_W-1:0] cam_reg [REG_NUM];
    t_res             expected_q [$];
    int               mismatch_cnt = 0;
    int               pend_cnt = 0;
    int               src_cnt [3] = '{0, 0, 0};

    assign o_pending = pend_cnt;
    assign o_src_cnt = src_cnt;

    function automatic logic signed [23:0] round_div_sat(longint num, longint den);
        longint mag;
        longint q;
        begin
            mag = (num < 0) ? -num : num;
            q   = (mag + den / 2) / den;
            if (num < 0) begin
                if (q > 64'sd8388608) q = 64'sd8388608;
                q = -q;
            end else if (q > 64'sd8388607) begin
                q = 64'sd8388607;
            end
            return q[23:0];
        end
    endfunction

    function automatic logic [15:0] clamp_depth(longint d);
        if (d < cam_reg[REG_FLOOR]) return cam_reg[REG_FLOOR];
        if (d > cam_reg[REG_CEILING]) return cam_reg[REG_CEILING];
        return d[15:0];
    endfunction

    function automatic t_res unproject_box(t_req r);
        t_res   p;
        longint fxf;
        longint fyf;
        longint du;
        longint dv;
        longint n;
        longint depth;
        begin
            fxf = (cam_reg[REG_FOCAL_X] < FOCAL_MIN) ? FOCAL_MIN : cam_reg[REG_FOCAL_X];
            fyf = (cam_reg[REG_FOCAL_Y] < FOCAL_MIN) ? FOCAL_MIN : cam_reg[REG_FOCAL_Y];
            du  = longint'(r.box_col) - longint'(cam_reg[REG_CENTER_COL]);
            dv  = longint'(r.box_row) - longint'(cam_reg[REG_CENTER_ROW]);
            if (r.box_height > BOX_HEIGHT_THRESHOLD) begin
                // apparent size uses the raw focal, not the floored one
                n = longint'(cam_reg[REG_OBST_H]) * longint'(cam_reg[REG_FOCAL_Y]);
                depth = clamp_depth((n + r.box_height / 2) / r.box_height);
                p.depth_source = SRC_SIZE;
            end else if (dv * 65536 > longint'(RAY_DROP_LIMIT) * fyf) begin
                n = longint'(cam_reg[REG_MOUNT_H]) * fyf;
                depth = clamp_depth((n + dv / 2) / dv);
                p.depth_source = SRC_GROUND;
            end else begin
                depth = FALLBACK_DEPTH & 16'hFFFF;
                p.depth_source = SRC_FALLBACK;
            end
            p.track_out   = r.track_tag;
            p.class_out   = r.class_tag;
            p.score_out   = r.score;
            p.pos_forward = depth[15:0];
            p.pos_right   = round_div_sat(du * depth, fxf);
            p.pos_down    = round_div_sat(dv * depth, fyf);
            p.vel_right   = round_div_sat(longint'(r.speed_col) * depth, fxf);
            p.vel_down    = round_div_sat(longint'(r.speed_row) * depth, fyf);
            return p;
        end
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v, inout bit bad);
        if (exp_v != act_v) begin
            bad = 1'b1;
            if (mismatch_cnt < 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name,
                         exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        bit   bad;
        if (!i_rst_n) begin
            cam_reg[REG_FOCAL_X]    <= RST_FOCAL_X;
            cam_reg[REG_FOCAL_Y]    <= RST_FOCAL_Y;
            cam_reg[REG_CENTER_COL] <= RST_CENTER_COL;
            cam_reg[REG_CENTER_ROW] <= RST_CENTER_ROW;
            cam_reg[REG_OBST_H]     <= RST_OBST_H;
            cam_reg[REG_MOUNT_H]    <= RST_MOUNT_H;
            cam_reg[REG_FLOOR]      <= RST_FLOOR;
            cam_reg[REG_CEILING]    <= RST_CEILING;
            expected_q.delete();
        end else begin
            if (i_res_vld) begin
                if (expected_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("%0t: result with no request outstanding", $realtime);
                    mismatch_cnt++;
                end else begin
                    e   = expected_q.pop_front();
                    bad = 1'b0;
                    check_field("track_out", e.track_out, i_res.track_out, bad);
                    check_field("class_out", e.class_out, i_res.class_out, bad);
                    check_field("score_out", e.score_out, i_res.score_out, bad);
                    check_field("pos_forward", e.pos_forward, i_res.pos_forward, bad);
                    check_field("pos_right", e.pos_right, i_res.pos_right, bad);
                    check_field("pos_down", e.pos_down, i_res.pos_down, bad);
                    check_field("vel_right", e.vel_right, i_res.vel_right, bad);
                    check_field("vel_down", e.vel_down, i_res.vel_down, bad);
                    check_field("depth_source", e.depth_source, i_res.depth_source, bad);
                    if (bad) mismatch_cnt++;
                end
            end
            // prediction uses the registers as they stand before this edge's write
            if (i_start && !i_busy) begin
                e = unproject_box(i_req);
                expected_q.insert(expected_q.size(), e);
                src_cnt[e.depth_source]++;
            end
            if (i_cfg_we) cam_reg[i_cfg_idx] <= i_cfg_data;
        end
        pend_cnt <= expected_q.size();
    end

    assign o_fail_cnt = mismatch_cnt;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Box depth unprojection testbench: directed boxes on the reset camera, then
// random bursts of boxes across several camera settings, extremes included.
// ----------------------------------------------------------------------------
module tb;
    import mbdu_pkg::*;

    localparam int N_RANDOM = 550;
    localparam int N_PHASES = 6;
    localparam int LATENCY  = 71;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_req             i_req = '0;
    logic             o_res_vld;
    t_res             o_res;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [REG_W-1:0] i_cfg_data = '0;
    int               fail_cnt;
    int               pending;
    int               src_cnt [3];
    int               box_cnt;
    logic [REG_W-1:0] cur_center_row;

    always #5 i_clk = ~i_clk;

    monocular_box_depth_unproject_top dut (
        .i_clk, .i_rst_n, .start, .busy, .i_req, .o_res_vld, .o_res,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    mbdu_checker chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_req, .i_res_vld(o_res_vld),
        .i_res(o_res), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_src_cnt(src_cnt)
    );

    // start stays high across a burst; each call holds one request until taken
    task automatic send_box(t_req r);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        box_cnt++;
    endtask

    task automatic pause(int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        pause(0);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_camera(logic [REG_W-1:0] v [REG_NUM]);
        for (int i = 0; i < REG_NUM; i++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= IDX_W'(i);
            i_cfg_data <= v[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_center_row = v[REG_CENTER_ROW];
    endtask

    function automatic t_req make_box(logic [15:0] col, logic [15:0] row, logic [15:0] h,
                                      logic [15:0] vc, logic [15:0] vr);
        t_req r;
        r.track_tag  = 16'($urandom);
        r.class_tag  = 8'($urandom);
        r.score      = 16'($urandom);
        r.box_col    = col;
        r.box_row    = row;
        r.box_height = h;
        r.speed_col  = vc;
        r.speed_row  = vr;
        return r;
    endfunction

    function automatic t_req random_box();
        int          row;
        logic [15:0] h;
        case ($urandom_range(0, 2))
            0: h = 16'($urandom);
            1: h = 16'($urandom_range(150, 170));
            default: h = 16'($urandom_range(0, 160));
        endcase
        // mostly near the horizon so the ground test goes both ways
        if ($urandom_range(0, 9) < 4) row = $urandom_range(0, 65535);
        else row = int'(cur_center_row) + $urandom_range(0, 6000) - 1500;
        if (row < 0) row = 0;
        if (row > 65535) row = 65535;
        return make_box(16'($urandom), 16'(row), h, 16'($urandom), 16'($urandom));
    endfunction

    initial begin
        logic [REG_W-1:0] cam [REG_NUM];
        int               per_phase;
        int               burst;
        cur_center_row = RST_CENTER_ROW;
        box_cnt = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset camera: size threshold edges, horizon, extremes of every field
        send_box(make_box(16'd0, 16'd0, 16'd0, 16'h8000, 16'h8000));
        send_box(make_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF));
        send_box(make_box(16'd5120, 16'd3840, 16'd160, 16'd0, 16'd0));
        send_box(make_box(16'd5120, 16'd3840, 16'd161, 16'd16, 16'hFFF0));
        send_box(make_box(16'd5120, 16'd3840, 16'd1, 16'd0, 16'd0));
        send_box(make_box(16'd5120, 16'd4240, 16'd0, 16'd100, 16'd100));
        send_box(make_box(16'd5120, 16'd4241, 16'd0, 16'd100, 16'd100));
        send_box(make_box(16'd5120, 16'd4242, 16'd160, 16'hFF00, 16'h0100));
        send_box(make_box(16'd0, 16'd3841, 16'd0, 16'h8000, 16'h7FFF));
        send_box(make_box(16'hFFFF, 16'd4000, 16'd40, 16'h7FFF, 16'h8000));
        send_box(make_box(16'd0, 16'hFFFF, 16'd0, 16'h8000, 16'h8000));
        send_box(make_box(16'd5000, 16'd0, 16'd0, 16'd1, 16'hFFFF));
        send_box(make_box(16'd5120, 16'd3840, 16'd162, 16'hFFFF, 16'd1));
        send_box(make_box(16'hFFFF, 16'hFFFF, 16'd65535, 16'h8000, 16'h8000));
        drain();

        per_phase = N_RANDOM / N_PHASES + 1;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: cam = '{RST_FOCAL_X, RST_FOCAL_Y, RST_CENTER_COL, RST_CENTER_ROW,
                           RST_OBST_H, RST_MOUNT_H, RST_FLOOR, RST_CEILING};
                // raw focal zero: floored to FOCAL_MIN (16), size depth collapses to floor
                1: cam = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
                2: cam = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           16'hFFFF, 16'hFFFF};
                // floor above ceiling
                3: cam = '{16'd16, 16'd16, 16'd5120, 16'd3840, 16'hFFFF, 16'hFFFF,
                           16'd3000, 16'd1000};
                default: begin
                    cam[REG_FOCAL_X]    = 16'($urandom_range(0, 20000));
                    cam[REG_FOCAL_Y]    = 16'($urandom_range(0, 20000));
                    cam[REG_CENTER_COL] = 16'($urandom);
                    cam[REG_CENTER_ROW] = 16'($urandom);
                    cam[REG_OBST_H]     = 16'($urandom);
                    cam[REG_MOUNT_H]    = 16'($urandom);
                    cam[REG_FLOOR]      = 16'($urandom_range(0, 2000));
                    cam[REG_CEILING]    = 16'($urandom_range(1000, 65535));
                end
            endcase
            write_camera(cam);
            for (int n = 0; n < per_phase; ) begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst && n < per_phase; k++, n++) send_box(random_box());
                if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
            end
            drain();
        end

        $display("Sent %0d boxes over %0d camera settings plus directed cases", box_cnt,
                 N_PHASES);
        $display("Depth sources: %0d apparent size, %0d ground plane, %0d fallback",
                 src_cnt[0], src_cnt[1], src_cnt[2]);
        if (fail_cnt == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Timeout waiting for results");
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
src/mbdu_pkg.sv
src/mbdu_div.sv
src/monocular_box_depth_unproject_top.sv
sim/mbdu_checker.sv
sim/tb.sv
